// ===== src/crpm_pkg.sv =====
package crpm_pkg;

	localparam int WINDOW = 10;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int TS_W = 32;
	localparam int MPR_W = 7;
	localparam logic [MPR_W-1:0] MPR_RESET = 7'd12;
	localparam int RPM_W = 24;
	localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};
	localparam int USED_W = 4;
	localparam logic [63:0] US_PER_MIN_Q8 = 64'd15360000000;
	localparam int NUM_W = $clog2(US_PER_MIN_Q8 * (WINDOW - 1) + 1);
	localparam int DEN_W = MPR_W + TS_W;
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [TS_W-1:0]   inst_delta;
		logic [TS_W-1:0]   avg_delta;
		logic [USED_W-1:0] nm1;
		logic [USED_W-1:0] pulses_used;
		logic              speed_valid;
	} crpm_entry_t;

endpackage

// ===== src/cadence_rpm_from_pulse_times_core.sv =====
// Cadence tachometer over a moving window of magnet-pulse timestamps.
// Input channel in_valid/in_ready carries one pulse item (pulse_time_us).
// Config channel cfg_valid/cfg_ready writes magnets_per_rev; always ready,
// write only while no item is in flight.
// Output channel out_valid/out_ready returns one result item per pulse:
// instant_rpm, average_rpm (Q16.8), pulses_used, speed_valid, saturated.
// The front updates the window and fill count as each item is accepted and
// pushes the interval data into a two-entry queue; the back runs one shared
// restoring divider, one quotient bit per cycle, at most once for each rate.
// Each division runs start, overflow check, 24 steps and done. With fewer
// than two pulses held both divisions are skipped; a zero interval skips
// its division and saturates that rate; an overflowing quotient ends the
// division after the check with the maximum quotient.
// The back takes a new queued item only once its last result is registered.
// Reset clears the window fill count, the queue and the output valid and
// loads magnets_per_rev with 12.
// When the receiver stalls, the result holds in the output register, the
// back waits with its next result, and the front keeps taking items until
// the queue fills, then drops in_ready.
module cadence_rpm_from_pulse_times_core import crpm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [MPR_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [TS_W-1:0]   pulse_time_us,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RPM_W-1:0]  instant_rpm,
	output logic [RPM_W-1:0]  average_rpm,
	output logic [USED_W-1:0] pulses_used,
	output logic              speed_valid,
	output logic              saturated
);

	logic [MPR_W-1:0] mpr_q;
	logic             q_full;
	logic             q_push;
	crpm_entry_t      q_wdata;
	logic             q_not_empty;
	logic             q_pop;
	crpm_entry_t      q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpr_q <= MPR_RESET;
		end else if (cfg_valid) begin
			mpr_q <= cfg_data;
		end
	end

	crpm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.pulse_time_us (pulse_time_us),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_wdata)
	);

	crpm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.not_empty (q_not_empty),
		.pop       (q_pop),
		.pop_data  (q_rdata)
	);

	crpm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.mpr         (mpr_q),
		.q_not_empty (q_not_empty),
		.q_pop       (q_pop),
		.q_data      (q_rdata),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.instant_rpm (instant_rpm),
		.average_rpm (average_rpm),
		.pulses_used (pulses_used),
		.speed_valid (speed_valid),
		.saturated   (saturated)
	);

endmodule

// ===== src/crpm_front.sv =====
module crpm_front import crpm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [TS_W-1:0]   pulse_time_us,
	input  logic              q_full,
	output logic              q_push,
	output crpm_entry_t       q_data
);

	logic [CNT_W-1:0] cnt_q;
	logic [TS_W-1:0]  sh_q [WINDOW-1];
	logic [TS_W-1:0]  first_q;
	logic [CNT_W-1:0] ncnt;
	logic [TS_W-1:0]  oldest;
	logic             full;

	assign in_ready = !q_full;
	assign q_push = in_valid && !q_full;
	assign full = (cnt_q == CNT_W'(WINDOW));

	always_comb begin
		ncnt = full ? cnt_q : cnt_q + CNT_W'(1);
		oldest = full ? sh_q[WINDOW-2] : first_q;
		q_data.inst_delta = pulse_time_us - sh_q[0];
		q_data.avg_delta = pulse_time_us - oldest;
		q_data.nm1 = USED_W'(ncnt - CNT_W'(1));
		q_data.pulses_used = USED_W'(ncnt);
		q_data.speed_valid = (ncnt >= CNT_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (q_push) begin
			cnt_q <= ncnt;
		end
	end

	always_ff @(posedge clk) begin
		if (q_push) begin
			if (cnt_q == '0) begin
				first_q <= pulse_time_us;
			end
			sh_q[0] <= pulse_time_us;
			for (int i = 1; i < WINDOW - 1; i++) begin
				sh_q[i] <= sh_q[i-1];
			end
		end
	end

endmodule

// ===== src/crpm_queue.sv =====
module crpm_queue import crpm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  crpm_entry_t push_data,
	output logic        full,
	output logic        not_empty,
	input  logic        pop,
	output crpm_entry_t pop_data
);

	crpm_entry_t       mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign full = (cnt_q == QCNT_W'(QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

// ===== src/crpm_div.sv =====
module crpm_div import crpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [RPM_W-1:0] quot
);

	localparam int CMP_W = DEN_W + RPM_W;
	localparam int STEP_W = $clog2(RPM_W);

	typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} dstate_t;

	dstate_t           state_q;
	logic [NUM_W-1:0]  num_q;
	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  rem_q;
	logic [RPM_W-1:0]  lo_q;
	logic [RPM_W-1:0]  quot_q;
	logic [STEP_W-1:0] step_q;
	logic              done_q;
	logic [DEN_W:0]    trial;
	logic              fits;

	assign done = done_q;
	assign quot = quot_q;
	assign trial = {rem_q, lo_q[RPM_W-1]};
	assign fits = (trial >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				D_IDLE: begin
					if (start) begin
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					if (CMP_W'(num_q) >= {den_q, {RPM_W{1'b0}}}) begin
						done_q <= 1'b1;
						state_q <= D_IDLE;
					end else begin
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (step_q == STEP_W'(RPM_W - 1)) begin
						done_q <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			D_IDLE: begin
				if (start) begin
					num_q <= num;
					den_q <= den;
				end
			end
			D_CHECK: begin
				quot_q <= RPM_MAX;
				rem_q <= DEN_W'(num_q[NUM_W-1:RPM_W]);
				lo_q <= num_q[RPM_W-1:0];
				step_q <= '0;
			end
			D_RUN: begin
				rem_q <= fits ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
				lo_q <= {lo_q[RPM_W-2:0], 1'b0};
				quot_q <= {quot_q[RPM_W-2:0], fits};
				step_q <= step_q + STEP_W'(1);
			end
			default: ;
		endcase
	end

endmodule

// ===== src/crpm_back.sv =====
module crpm_back import crpm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [MPR_W-1:0]  mpr,
	input  logic              q_not_empty,
	output logic              q_pop,
	input  crpm_entry_t       q_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [RPM_W-1:0]  instant_rpm,
	output logic [RPM_W-1:0]  average_rpm,
	output logic [USED_W-1:0] pulses_used,
	output logic              speed_valid,
	output logic              saturated
);

	typedef enum logic [2:0] {
		S_IDLE, S_INST_GO, S_INST_WAIT, S_AVG_GO, S_AVG_WAIT, S_OUT
	} bstate_t;

	bstate_t          state_q;
	crpm_entry_t      e_q;
	logic [RPM_W-1:0] inst_q;
	logic [RPM_W-1:0] avg_q;
	logic             sat_q;
	logic [MPR_W-1:0] mpr_eff;
	logic             div_start;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [RPM_W-1:0] div_quot;
	logic [TS_W-1:0]  delta;

	assign q_pop = (state_q == S_IDLE) && q_not_empty;
	assign mpr_eff = (mpr == '0) ? MPR_W'(1) : mpr;
	assign delta = (state_q == S_AVG_GO) ? e_q.avg_delta : e_q.inst_delta;
	assign div_den = DEN_W'(mpr_eff) * DEN_W'(delta);
	assign div_num = (state_q == S_AVG_GO) ?
		NUM_W'(US_PER_MIN_Q8) * NUM_W'(e_q.nm1) : NUM_W'(US_PER_MIN_Q8);
	assign div_start = ((state_q == S_INST_GO) || (state_q == S_AVG_GO)) &&
		e_q.speed_valid && (delta != '0);

	crpm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && (!out_valid || out_ready)) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_not_empty) begin
						state_q <= S_INST_GO;
					end
				end
				S_INST_GO: begin
					if (!e_q.speed_valid) begin
						state_q <= S_OUT;
					end else if (div_start) begin
						state_q <= S_INST_WAIT;
					end else begin
						state_q <= S_AVG_GO;
					end
				end
				S_INST_WAIT: begin
					if (div_done) begin
						state_q <= S_AVG_GO;
					end
				end
				S_AVG_GO: begin
					state_q <= div_start ? S_AVG_WAIT : S_OUT;
				end
				S_AVG_WAIT: begin
					if (div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				e_q <= q_data;
				inst_q <= '0;
				avg_q <= '0;
				sat_q <= 1'b0;
			end
			S_INST_GO: begin
				if (e_q.speed_valid && !div_start) begin
					inst_q <= RPM_MAX;
					sat_q <= 1'b1;
				end
			end
			S_INST_WAIT: begin
				if (div_done) begin
					inst_q <= div_quot;
				end
			end
			S_AVG_GO: begin
				if (!div_start) begin
					avg_q <= RPM_MAX;
					sat_q <= 1'b1;
				end
			end
			S_AVG_WAIT: begin
				if (div_done) begin
					avg_q <= div_quot;
				end
			end
			S_OUT: begin
				if (!out_valid || out_ready) begin
					instant_rpm <= inst_q;
					average_rpm <= avg_q;
					pulses_used <= e_q.pulses_used;
					speed_valid <= e_q.speed_valid;
					saturated <= sat_q;
				end
			end
			default: ;
		endcase
	end

endmodule
